/* rtl/gcr_pkg.sv */
// Shared types and constants for the gradient color ramp.
`timescale 1ns / 1ps
`default_nettype none
package gcr_pkg;
	localparam int OFF_W = 17;
	localparam int CH_W = 8;
	localparam int STOP_W = 49;
	localparam int CFG_IDX_W = 4;
	localparam logic [OFF_W-1:0] ONE_Q16 = 17'h10000;

	typedef enum logic [1:0] {
		WRAP_NONE    = 2'd0,
		WRAP_PAD     = 2'd1,
		WRAP_REPEAT  = 2'd2,
		WRAP_REFLECT = 2'd3
	} wrap_t;

	localparam logic [CFG_IDX_W-1:0] REG_WRAP = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STOP0 = 4'd2;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
		logic [CH_W-1:0] a;
	} rgba_t;
endpackage
`default_nettype wire

/* rtl/gcr_div.sv */
// Pipelined restoring divider producing a 17-bit quotient, one bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module gcr_div #(
	parameter int SIDE_W = 1
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire logic                           in_vld,
	input  wire logic [gcr_pkg::OFF_W-1:0]      num,
	input  wire logic [gcr_pkg::OFF_W-1:0]      den,
	input  wire logic [SIDE_W-1:0]              side_in,
	output logic                                out_vld,
	output logic [gcr_pkg::OFF_W-1:0]           quo,
	output logic [SIDE_W-1:0]                   side_out
);
	localparam int QW = gcr_pkg::OFF_W;
	localparam int RW = QW + 1;

	// Dividend is num << 16. Since num <= den, its top 16 bits are below den, so the
	// first partial remainder is num >> 1 and the first stage shifts in num[0];
	// every later stage shifts in a zero.
	logic          vld_s [QW];
	logic [RW-1:0] rem_s [QW-1];
	logic [QW-1:0] den_s [QW-1];
	logic [QW-1:0] q_s   [QW];
	logic [SIDE_W-1:0] sd_s [QW];
	logic [RW:0]   sh_c   [QW];
	logic [RW:0]   diff_c [QW];

	always_comb begin
		sh_c[0] = {2'b00, num};
		diff_c[0] = sh_c[0] - {2'b00, den};
		for (int i = 1; i < QW; i++) begin
			sh_c[i] = {rem_s[i-1], 1'b0};
			diff_c[i] = sh_c[i] - {2'b00, den_s[i-1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QW; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
			for (int i = 1; i < QW; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= diff_c[0][RW] ? sh_c[0][RW-1:0] : diff_c[0][RW-1:0];
			den_s[0] <= den;
			q_s[0] <= {{(QW-1){1'b0}}, !diff_c[0][RW]};
			sd_s[0] <= side_in;
			for (int i = 1; i < QW-1; i++) begin
				rem_s[i] <= diff_c[i][RW] ? sh_c[i][RW-1:0] : diff_c[i][RW-1:0];
				den_s[i] <= den_s[i-1];
			end
			for (int i = 1; i < QW; i++) begin
				q_s[i] <= {q_s[i-1][QW-2:0], !diff_c[i][RW]};
				sd_s[i] <= sd_s[i-1];
			end
		end
	end

	assign out_vld = vld_s[QW-1];
	assign quo = q_s[QW-1];
	assign side_out = sd_s[QW-1];
endmodule
`default_nettype wire

/* rtl/gradient_color_ramp.sv */
// Top level of the gradient color ramp: wrap, stop search, weight, blend.
// Usage:
// Input channel t_param (signed Q8.16) with valid/ready; output channel
// red/green/blue/alpha with valid/ready. Configuration goes through a plain
// write port (cfg_we, cfg_idx, cfg_data) and must only be written while idle.
// One beat enters per clock unless stalled. From input accept to output valid
// a beat passes the wrap register, which loads at the accept edge, then the
// stop search and operand setup register, a 17-stage divider that produces one
// quotient bit per stage, the blend multiply register and the output register.
// Throughput is one beat per cycle unless stalled; the divider sets the latency.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, every stage holds and ready drops only if the last stage
// is full, so nothing is lost or repeated.
// Reset clears all valid bits and loads wrap mode pad, one stop, and zero
// stops.
`timescale 1ns / 1ps
`default_nettype none
module gradient_color_ramp #(
	parameter int MAX_STOPS = 6
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        valid,
	output logic             ready,
	input  wire logic signed [23:0] t_param,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic [7:0]       alpha,
	input  wire logic        cfg_we,
	input  wire logic [gcr_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [gcr_pkg::STOP_W-1:0]    cfg_data
);
	localparam int OW = gcr_pkg::OFF_W;
	localparam int NS = 6;
	localparam int KW = $clog2(NS + 1);

	// How a beat leaves the wrap stage.
	typedef enum logic [1:0] {
		MD_LOOKUP = 2'd0,
		MD_ZERO   = 2'd1,
		MD_FIRST  = 2'd2,
		MD_LAST   = 2'd3
	} md_t;

	logic [1:0] wrap_q;
	logic [2:0] count_q;
	logic [gcr_pkg::STOP_W-1:0] stop_q [NS];

	function automatic logic [gcr_pkg::CFG_IDX_W-1:0] CFG_I(input int i);
		return gcr_pkg::CFG_IDX_W'(i);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q <= gcr_pkg::WRAP_PAD;
			count_q <= 3'd1;
			for (int i = 0; i < NS; i++) stop_q[i] <= '0;
		end else if (cfg_we) begin
			if (cfg_idx == gcr_pkg::REG_WRAP) wrap_q <= cfg_data[1:0];
			else if (cfg_idx == gcr_pkg::REG_COUNT) count_q <= cfg_data[2:0];
			else for (int i = 0; i < NS; i++)
				if (cfg_idx == gcr_pkg::REG_STOP0 + CFG_I(i)) stop_q[i] <= cfg_data;
		end
	end

	// Stops in use, clamped to [1, MAX_STOPS].
	logic [KW-1:0] n_use;
	always_comb begin
		n_use = KW'(count_q);
		if (count_q == 3'd0) n_use = KW'(1);
		if (count_q > 3'(MAX_STOPS)) n_use = KW'(MAX_STOPS);
	end

	function automatic logic [OW-1:0] off_of(input logic [gcr_pkg::STOP_W-1:0] s);
		return s[48:32];
	endfunction

	// The pipeline moves as one; it holds only when the final beat is stuck.
	logic en;
	assign en = !out_valid || out_ready;
	assign ready = en;

	// Stage 1: wrap mapping.
	logic        vld_s1;
	md_t         md_s1;
	logic [OW-1:0] t_s1;
	md_t         md_c;
	logic [OW-1:0] t_c;
	logic [23:0] a_c;
	logic [OW:0] m_c;
	always_comb begin
		md_c = MD_LOOKUP;
		t_c = t_param[OW-1:0];
		a_c = t_param[23] ? 24'(-t_param) : t_param;
		m_c = {1'b0, a_c[OW-1:0]};
		case (gcr_pkg::wrap_t'(wrap_q))
			gcr_pkg::WRAP_NONE: begin
				if (t_param < 0 || t_param > 24'sh010000) md_c = MD_ZERO;
			end
			gcr_pkg::WRAP_PAD: begin
				if (t_param < 0) md_c = MD_FIRST;
				else if (t_param > 24'sh010000) md_c = MD_LAST;
			end
			gcr_pkg::WRAP_REPEAT: t_c = {1'b0, t_param[15:0]};
			default: begin
				if (m_c > {1'b0, gcr_pkg::ONE_Q16}) m_c = 18'h20000 - m_c;
				t_c = m_c[OW-1:0];
			end
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			md_s1 <= md_c;
			t_s1 <= t_c;
		end
	end

	// Stage 2: stop search; choose the two stops and the blend operands.
	logic [KW-1:0] k_c;
	logic found;
	always_comb begin
		k_c = n_use;
		found = 1'b0;
		for (int i = 0; i < NS; i++) begin
			if (!found && KW'(i) < n_use && off_of(stop_q[i]) >= t_s1) begin
				k_c = KW'(i);
				found = 1'b1;
			end
		end
	end

	logic        blend_c;
	gcr_pkg::rgba_t cp_c, cq_c;
	logic [OW-1:0] num_c, den_c;
	always_comb begin
		blend_c = 1'b0;
		num_c = '0;
		den_c = OW'(1);
		cp_c = '0;
		cq_c = '0;
		if (md_s1 == MD_FIRST || (md_s1 == MD_LOOKUP && k_c == '0)) begin
			cp_c = stop_q[0][31:0];
		end else if (md_s1 == MD_LAST || (md_s1 == MD_LOOKUP && k_c == n_use)) begin
			for (int i = 0; i < NS; i++)
				if (KW'(i) == n_use - KW'(1)) cp_c = stop_q[i][31:0];
		end else if (md_s1 == MD_LOOKUP) begin
			blend_c = 1'b1;
			for (int i = 1; i < NS; i++)
				if (KW'(i) == k_c) begin
					cp_c = stop_q[i-1][31:0];
					cq_c = stop_q[i][31:0];
					num_c = t_s1 - off_of(stop_q[i-1]);
					den_c = off_of(stop_q[i]) - off_of(stop_q[i-1]);
				end
		end
	end

	logic        vld_s2;
	logic        blend_s2;
	gcr_pkg::rgba_t cp_s2, cq_s2;
	logic [OW-1:0] num_s2, den_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			blend_s2 <= blend_c;
			cp_s2 <= cp_c;
			cq_s2 <= cq_c;
			num_s2 <= num_c;
			den_s2 <= den_c;
		end
	end

	// Divider stages.
	localparam int SW = 1 + 64;
	logic dv_vld;
	logic [OW-1:0] w_d;
	logic [SW-1:0] sd_o;
	gcr_div #(.SIDE_W(SW)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s2),
		.num(num_s2), .den(den_s2), .side_in({blend_s2, cp_s2, cq_s2}),
		.out_vld(dv_vld), .quo(w_d), .side_out(sd_o)
	);
	logic blend_d;
	gcr_pkg::rgba_t cp_d, cq_d;
	assign {blend_d, cp_d, cq_d} = sd_o;

	// Blend stage A: products per channel.
	logic vld_s3;
	logic blend_s3;
	gcr_pkg::rgba_t cp_s3;
	logic [24:0] pa_s3 [4];
	logic [24:0] pb_s3 [4];
	logic [OW-1:0] iw;
	logic [7:0] cpc [4];
	logic [7:0] cqc [4];
	assign iw = gcr_pkg::ONE_Q16 - w_d;
	assign cpc = '{cp_d.r, cp_d.g, cp_d.b, cp_d.a};
	assign cqc = '{cq_d.r, cq_d.g, cq_d.b, cq_d.a};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= dv_vld;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			blend_s3 <= blend_d;
			cp_s3 <= cp_d;
			for (int c = 0; c < 4; c++) begin
				pa_s3[c] <= 25'(cpc[c]) * 25'(iw);
				pb_s3[c] <= 25'(cqc[c]) * 25'(w_d);
			end
		end
	end

	// Blend stage B: sum, round, output register.
	logic [25:0] sum_c [4];
	always_comb
		for (int c = 0; c < 4; c++)
			sum_c[c] = 26'(pa_s3[c]) + 26'(pb_s3[c]) + 26'h8000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= vld_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			if (blend_s3) begin
				red <= sum_c[0][23:16];
				green <= sum_c[1][23:16];
				blue <= sum_c[2][23:16];
				alpha <= sum_c[3][23:16];
			end else begin
				red <= cp_s3.r;
				green <= cp_s3.g;
				blue <= cp_s3.b;
				alpha <= cp_s3.a;
			end
		end
	end
endmodule
`default_nettype wire

/* rtl/gcr_checker.sv */
// Port-level checker for the gradient color ramp, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module gcr_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [7:0] red
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red))
		else $error("result dropped or changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> ready)
		else $error("input refused with empty output");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !ready)
		else $error("input taken while output stalled");
endmodule

bind gradient_color_ramp gcr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .ready(ready),
	.out_valid(out_valid), .out_ready(out_ready), .red(red)
);
`default_nettype wire

/* tb/tb_gradient_color_ramp.sv */
// Self-checking testbench for the gradient color ramp: random parameters, stop sets and stalls.
`timescale 1ns / 1ps
`default_nettype none

class ramp_scoreboard;
	gcr_pkg::rgba_t colors_due[$];
	int unsigned mismatches;
	int unsigned matched;

	function new();
		mismatches = 0;
		matched = 0;
	endfunction

	function void note_color(gcr_pkg::rgba_t c);
		colors_due.push_back(c);
	endfunction

	function void check_color(gcr_pkg::rgba_t got);
		gcr_pkg::rgba_t want;
		if (colors_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: unexpected color %h", got);
			return;
		end
		want = colors_due.pop_front();
		if (want.r !== got.r || want.g !== got.g || want.b !== got.b || want.a !== got.a) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: color mismatch expected %h actual %h", want, got);
		end else
			matched++;
	endfunction
endclass

module tb_gradient_color_ramp;
	import gcr_pkg::*;

	localparam int N_STOPS = 6;
	localparam int LATENCY = 20;
	localparam int WATCHDOG = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic valid = 1'b0;
	logic ready;
	logic signed [23:0] t_param = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] red, green, blue, alpha;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [STOP_W-1:0] cfg_data = '0;

	// Shadow copy of the configuration.
	wrap_t shadow_wrap;
	logic [2:0] shadow_count;
	logic [STOP_W-1:0] shadow_stop [N_STOPS];

	ramp_scoreboard sb;
	int unsigned idle_cycles = 0;
	int unsigned beats_in = 0;
	bit calm = 1'b0;
	bit sink_on = 1'b0;
	int unsigned sink_hold = 0;

	gradient_color_ramp #(.MAX_STOPS(N_STOPS)) dut (
		.clk(clk), .arst_n(arst_n), .valid(valid), .ready(ready), .t_param(t_param),
		.out_valid(out_valid), .out_ready(out_ready), .red(red), .green(green),
		.blue(blue), .alpha(alpha), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int unsigned live_stops();
		int unsigned n;
		n = shadow_count;
		if (n == 0)
			n = 1;
		if (n > N_STOPS)
			n = N_STOPS;
		return n;
	endfunction

	function automatic logic [16:0] stop_off(int unsigned i);
		return shadow_stop[i][48:32];
	endfunction

	function automatic rgba_t stop_color(int unsigned i);
		return rgba_t'(shadow_stop[i][31:0]);
	endfunction

	function automatic rgba_t ramp_color(logic [16:0] te);
		int unsigned n, k;
		logic [16:0] op, oq;
		logic [63:0] w, cp, cq, v;
		logic [31:0] pc, qc, res;
		n = live_stops();
		k = 0;
		while (k < n && stop_off(k) < te)
			k++;
		if (k == 0)
			return stop_color(0);
		if (k == n)
			return stop_color(n - 1);
		op = stop_off(k - 1);
		oq = stop_off(k);
		w = (64'(te - op) << 16) / 64'(oq - op);
		pc = shadow_stop[k - 1][31:0];
		qc = shadow_stop[k][31:0];
		for (int ch = 0; ch < 4; ch++) begin
			cp = 64'(pc[8 * ch +: 8]);
			cq = 64'(qc[8 * ch +: 8]);
			v = (cp * (64'd65536 - w) + cq * w + 64'd32768) >> 16;
			res[8 * ch +: 8] = v[7:0];
		end
		return rgba_t'(res);
	endfunction

	function automatic rgba_t shade_param(logic signed [23:0] t);
		longint ts, a, m;
		ts = t;
		case (shadow_wrap)
			WRAP_NONE: begin
				if (ts < 0 || ts > 65536)
					return '0;
				return ramp_color(17'(ts));
			end
			WRAP_PAD: begin
				if (ts < 0)
					return stop_color(0);
				if (ts > 65536)
					return stop_color(live_stops() - 1);
				return ramp_color(17'(ts));
			end
			WRAP_REPEAT:
				return ramp_color({1'b0, t[15:0]});
			default: begin
				a = ts < 0 ? -ts : ts;
				m = a % 131072;
				if (m > 65536)
					m = 131072 - m;
				return ramp_color(17'(m));
			end
		endcase
	endfunction

	// Leaves the write enable high; the caller drops it after the last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STOP_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		if (idx == REG_WRAP)
			shadow_wrap = wrap_t'(data[1:0]);
		else if (idx == REG_COUNT)
			shadow_count = data[2:0];
		else if (idx >= REG_STOP0 && idx < REG_STOP0 + N_STOPS)
			shadow_stop[idx - REG_STOP0] = data;
	endtask

	task automatic send_param(input logic signed [23:0] t);
		if (!calm && $urandom_range(0, 3) == 0) begin
			valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		valid <= 1'b1;
		t_param <= t;
		do
			@(posedge clk);
		while (!ready);
		sb.note_color(shade_param(t));
		beats_in++;
	endtask

	task automatic drain();
		valid <= 1'b0;
		while (sb.colors_due.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Writes a stop set; sorted unless asked otherwise, offsets sometimes at the ends.
	task automatic load_stops(input bit sorted, input int unsigned count, input int unsigned mode);
		logic [16:0] offs [N_STOPS];
		for (int i = 0; i < N_STOPS; i++) begin
			offs[i] = 17'($urandom_range(0, 65536));
			if ($urandom_range(0, 5) == 0)
				offs[i] = $urandom_range(0, 1) ? 17'd65536 : 17'd0;
			if ($urandom_range(0, 9) == 0)
				offs[i] = 17'($urandom);
		end
		if (sorted)
			offs.sort();
		for (int i = 0; i < N_STOPS; i++)
			write_reg(REG_STOP0 + CFG_IDX_W'(i), {offs[i], 32'($urandom)});
		write_reg(REG_WRAP, STOP_W'(mode));
		write_reg(REG_COUNT, STOP_W'(count));
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [23:0] pick_param();
		case ($urandom_range(0, 5))
			0: return 24'($urandom);
			1: return 24'($urandom_range(0, 65536));
			2: return 24'($urandom_range(0, 65536)) - 24'sd65536;
			3: return 24'($urandom_range(0, 262144)) - 24'sd131072;
			4: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
			default: return 24'sd65536 + 24'($urandom_range(0, 2)) - 24'sd1;
		endcase
	endfunction

	// Output side: random stall bursts, checks every accepted beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_color({red, green, blue, alpha});
			if (sink_hold != 0)
				sink_hold <= sink_hold - 1;
			else if (!calm && sink_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				sink_hold <= $urandom_range(1, 17);
			end else
				out_ready <= sink_on;
		end
	end

	always @(posedge clk) begin
		if ((valid && ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("Watchdog expired after %0d beats in", beats_in);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		logic signed [23:0] corner [10];
		sb = new();
		shadow_wrap = WRAP_PAD;
		shadow_count = 3'd1;
		foreach (shadow_stop[i])
			shadow_stop[i] = '0;
		corner = '{24'sh800000, 24'sh7fffff, 24'sd0, 24'sd65536, 24'sd65537, -24'sd1,
			24'sd131072, 24'sd131073, -24'sd65536, 24'sd32768};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		sink_on = 1'b1;
		@(posedge clk);

		// Reset defaults, then each wrap mode over the corner parameters.
		send_param(24'sd100);
		send_param(-24'sd100);
		drain();
		for (int md = 0; md < 4; md++) begin
			load_stops(1'b1, 4, md);
			for (int i = 0; i < 5; i++)
				send_param(corner[(i + md * 3) % 10]);
			drain();
		end
		// Stop count of zero and above the maximum, unsorted stops, bad index.
		load_stops(1'b0, 0, WRAP_REFLECT);
		send_param(24'sd40000);
		drain();
		write_reg(4'd15, '1);
		load_stops(1'b0, 7, WRAP_NONE);
		send_param(24'sd20000);
		send_param(24'sd65536);
		drain();

		for (int ph = 0; ph < 35; ph++) begin
			calm = ph >= 31;
			load_stops($urandom_range(0, 4) != 0,
				ph == 0 ? 6 : (ph == 1 ? 1 : $urandom_range(0, 7)), $urandom_range(0, 3));
			repeat (50)
				send_param(pick_param());
			drain();
		end

		$display("Covered %0d parameters over all wrap modes and stop counts 0 to 7;",
			beats_in);
		$display("%0d colors matched, %0d mismatched.", sb.matched, sb.mismatches);
		if (sb.mismatches == 0 && sb.colors_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire

/* files.f */
rtl/gcr_pkg.sv
rtl/gcr_div.sv
rtl/gradient_color_ramp.sv
rtl/gcr_checker.sv
tb/tb_gradient_color_ramp.sv
